// ===== sv/pdl_pkg.sv =====
package pdl_pkg;

  typedef enum logic [2:0] {
    PH_SETUP_FIRST,
    PH_SETUP_SECOND,
    PH_MENU,
    PH_CONFIRM,
    PH_DOOR_CW,
    PH_DOOR_OFF,
    PH_DOOR_ACW,
    PH_ALARM
  } phase_t;

  // reply codes
  localparam logic [1:0] RC_WRONG   = 2'd0;
  localparam logic [1:0] RC_RIGHT   = 2'd1;
  localparam logic [1:0] RC_CONF    = 2'd2;
  localparam logic [1:0] RC_NOTCONF = 2'd3;

  // motor drive codes
  localparam logic [1:0] MOTOR_OFF = 2'd0;
  localparam logic [1:0] MOTOR_CW  = 2'd1;
  localparam logic [1:0] MOTOR_ACW = 2'd2;

  // menu letters
  localparam logic [7:0] CHAR_OPEN   = 8'h6F;  // 'o'
  localparam logic [7:0] CHAR_CHANGE = 8'h70;  // 'p'

  // register indexes
  localparam logic [1:0] REG_DOOR_STEP = 2'd0;
  localparam logic [1:0] REG_ALARM     = 2'd1;
  localparam logic [1:0] REG_MAX_ATT   = 2'd2;

  localparam logic [7:0] DOOR_STEP_RST = 8'd15;
  localparam logic [7:0] ALARM_RST     = 8'd60;
  localparam logic [2:0] MAX_ATT_RST   = 3'd3;

  localparam logic [7:0] SEC_MAX = 8'hFF;

  typedef struct packed {
    logic       reply_valid;
    logic [1:0] reply_code;
    logic [1:0] motor_drive;
    logic       buzzer_active;
  } out_item_t;

endpackage

// ===== sv/pdl_in_if.sv =====
interface pdl_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink (input valid, input mode, input byte_value, output ready);
endinterface

// ===== sv/pdl_out_if.sv =====
interface pdl_out_if;
  logic       valid;
  logic       ready;
  logic       reply_valid;
  logic [1:0] reply_code;
  logic [1:0] motor_drive;
  logic       buzzer_active;

  modport source (output valid, output reply_valid, output reply_code,
                  output motor_drive, output buzzer_active, input ready);
  modport sink (input valid, input reply_valid, input reply_code,
                input motor_drive, input buzzer_active, output ready);
endinterface

// ===== sv/pdl_cfg_if.sv =====
interface pdl_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] reg_index;
  logic [7:0] data;

  modport source (output valid, output reg_index, output data, input ready);
  modport sink (input valid, input reg_index, input data, output ready);
endinterface

// ===== sv/pdl_ram.sv =====
module pdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/password_door_lock_controller_top.sv =====
// Password door lock controller.
// in_if  : one item per handshake; mode 0 carries a received byte, mode 1 a
//          one-second tick (byte_value then unused).
// out_if : exactly one item per input item: reply flag and code, plus the
//          motor drive and buzzer state as left by that input item.
// cfg_if : register writes (0 door step seconds, 1 alarm seconds,
//          2 max attempts); always ready, only to be used while idle.
// Output: a result is registered in the output register in the cycle after its input
//          item is taken. Throughput: one item per cycle, sustained while out_if.ready stays high.
// Both code entries share one RAM split in two banks of CODE_LEN bytes
// (each bank rounded up to a power of two); a bank pointer swaps roles when
// setup succeeds, so no copy is needed.
// The RAM is read one item ahead: its address follows the next state, so the
// byte for the coming comparison is already registered when the item arrives.
// Reset: setup, first entry, index zero, registers at 15 / 60 / 3. The code
//        RAM is not cleared; it is always written before it is read.
// Stall: while a result waits on out_if no further item is taken;
//        in_if.ready drops exactly when the output register is full and
//        out_if.ready is low.
module password_door_lock_controller_top #(
  parameter int CODE_LEN = 5
) (
  input  logic clk,
  input  logic rst_n,
  pdl_in_if.sink    in_if,
  pdl_out_if.source out_if,
  pdl_cfg_if.sink   cfg_if
);
  import pdl_pkg::*;

  localparam int IW    = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int AW    = IW + 1;
  localparam int DEPTH = 2 ** AW;
  localparam logic [IW-1:0] LAST_IDX = IW'(CODE_LEN - 1);

  // configuration
  logic [7:0] door_step_r, alarm_r;
  logic [2:0] max_att_r;

  // control state
  phase_t        phase_r, phase_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          sel_r, sel_nxt;      // bank holding the stored code
  logic          mis_r, mis_nxt;
  logic [2:0]    fail_r, fail_nxt;
  logic [7:0]    sec_r, sec_nxt;
  logic          open_r, open_nxt;

  // output register
  logic      out_valid_r;
  out_item_t out_data_r, res;

  // RAM side
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    rdata, cur_byte, fwd_data_r;
  logic          fwd_r, rd_bank;

  logic       acc;
  logic       is_byte;
  logic       mis_now;
  logic [7:0] sec_inc, limit;
  logic [2:0] fail_inc;
  logic       last;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign acc         = in_if.valid && in_if.ready;
  assign is_byte     = !in_if.mode;
  assign cfg_if.ready = 1'b1;

  // same-edge write / read of one entry: take the written byte
  assign cur_byte = fwd_r ? fwd_data_r : rdata;
  assign mis_now  = mis_r || (cur_byte != in_if.byte_value);
  assign last     = (idx_r == LAST_IDX);
  assign sec_inc  = (sec_r == SEC_MAX) ? sec_r : sec_r + 8'd1;
  assign limit    = (phase_r == PH_ALARM) ? alarm_r : door_step_r;
  assign fail_inc = fail_r + 3'd1;

  assign we    = acc && is_byte && (phase_r == PH_SETUP_FIRST);
  assign waddr = {~sel_r, idx_r};

  // next-state and result
  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    sel_nxt   = sel_r;
    mis_nxt   = mis_r;
    fail_nxt  = fail_r;
    sec_nxt   = sec_r;
    open_nxt  = open_r;
    res.reply_valid = 1'b0;
    res.reply_code  = RC_WRONG;

    if (acc) begin
      if (!is_byte) begin
        // one-second tick
        if (phase_r == PH_DOOR_CW || phase_r == PH_DOOR_OFF ||
            phase_r == PH_DOOR_ACW || phase_r == PH_ALARM) begin
          if (sec_inc >= limit) begin
            sec_nxt = '0;
            unique case (phase_r)
              PH_DOOR_CW:  phase_nxt = PH_DOOR_OFF;
              PH_DOOR_OFF: phase_nxt = PH_DOOR_ACW;
              default:     phase_nxt = PH_MENU;
            endcase
          end else begin
            sec_nxt = sec_inc;
          end
        end
      end else begin
        unique case (phase_r)
          PH_SETUP_FIRST: begin
            if (last) begin
              idx_nxt   = '0;
              mis_nxt   = 1'b0;
              phase_nxt = PH_SETUP_SECOND;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          PH_SETUP_SECOND: begin
            if (last) begin
              idx_nxt = '0;
              mis_nxt = 1'b0;
              res.reply_valid = 1'b1;
              if (mis_now) begin
                res.reply_code = RC_WRONG;
                phase_nxt      = PH_SETUP_FIRST;
              end else begin
                res.reply_code = RC_RIGHT;
                sel_nxt        = ~sel_r;
                phase_nxt      = PH_MENU;
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
              mis_nxt = mis_now;
            end
          end
          PH_MENU: begin
            if (in_if.byte_value == CHAR_OPEN || in_if.byte_value == CHAR_CHANGE) begin
              open_nxt  = (in_if.byte_value == CHAR_OPEN);
              idx_nxt   = '0;
              mis_nxt   = 1'b0;
              phase_nxt = PH_CONFIRM;
            end
          end
          PH_CONFIRM: begin
            if (last) begin
              idx_nxt = '0;
              mis_nxt = 1'b0;
              res.reply_valid = 1'b1;
              if (!mis_now) begin
                res.reply_code = RC_CONF;
                fail_nxt       = '0;
                if (open_r) begin
                  phase_nxt = PH_DOOR_CW;
                  sec_nxt   = '0;
                end else begin
                  phase_nxt = PH_SETUP_FIRST;
                end
              end else begin
                res.reply_code = RC_NOTCONF;
                if (fail_inc >= max_att_r) begin
                  fail_nxt  = '0;
                  phase_nxt = PH_ALARM;
                  sec_nxt   = '0;
                end else begin
                  fail_nxt = fail_inc;
                end
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
              mis_nxt = mis_now;
            end
          end
          default: ;  // door moving or alarm: byte dropped
        endcase
      end
    end

    unique case (phase_nxt)
      PH_DOOR_CW:  res.motor_drive = MOTOR_CW;
      PH_DOOR_ACW: res.motor_drive = MOTOR_ACW;
      default:     res.motor_drive = MOTOR_OFF;
    endcase
    res.buzzer_active = (phase_nxt == PH_ALARM);

    // setup reads the entry bank, confirm the stored bank
    rd_bank = (phase_nxt == PH_CONFIRM) ? sel_nxt : ~sel_nxt;
  end

  assign raddr = {rd_bank, idx_nxt};

  pdl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_code_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_if.byte_value),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    fwd_r      <= we && (waddr == raddr);
    fwd_data_r <= in_if.byte_value;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SETUP_FIRST;
      idx_r   <= '0;
      sel_r   <= 1'b0;
      mis_r   <= 1'b0;
      fail_r  <= '0;
      sec_r   <= '0;
      open_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      sel_r   <= sel_nxt;
      mis_r   <= mis_nxt;
      fail_r  <= fail_nxt;
      sec_r   <= sec_nxt;
      open_r  <= open_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_step_r <= DOOR_STEP_RST;
      alarm_r     <= ALARM_RST;
      max_att_r   <= MAX_ATT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      unique case (cfg_if.reg_index)
        REG_DOOR_STEP: door_step_r <= cfg_if.data;
        REG_ALARM:     alarm_r     <= cfg_if.data;
        REG_MAX_ATT:   max_att_r   <= cfg_if.data[2:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_data_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.reply_valid   = out_data_r.reply_valid;
  assign out_if.reply_code    = out_data_r.reply_code;
  assign out_if.motor_drive   = out_data_r.motor_drive;
  assign out_if.buzzer_active = out_data_r.buzzer_active;

  // motor and buzzer never run together
  a_motor_buzzer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.buzzer_active && out_data_r.motor_drive != MOTOR_OFF))
    else $error("motor and buzzer active together");

  // door only starts on a confirmed code
  a_open_conf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.reply_valid && out_data_r.motor_drive == MOTOR_CW)
    |-> out_data_r.reply_code == RC_CONF)
    else $error("door opened without confirmation");

  // alarm only starts on a failed confirmation
  a_alarm_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.reply_valid && out_data_r.buzzer_active)
    |-> out_data_r.reply_code == RC_NOTCONF)
    else $error("alarm raised without failed confirmation");

  // bytes during door movement or alarm give no reply
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && is_byte && (phase_r == PH_DOOR_CW || phase_r == PH_DOOR_OFF ||
     phase_r == PH_DOOR_ACW || phase_r == PH_ALARM))
    |=> !out_data_r.reply_valid)
    else $error("reply while door moving or alarm sounding");

endmodule
